### rtl/core/isstore_pkg.sv
`timescale 1ns / 1ps

package isstore_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Widths of the port fields.
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 9;

  // Index and count are compared at a width that holds both.
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [FILL_W-1:0]    fill_t;

  localparam cnt_t DEPTH_C = CNT_W'(DEPTH);
  localparam cmp_t DEPTH_X = CMP_W'(DEPTH);

  localparam kind_t K_PUSH   = 3'd0;
  localparam kind_t K_POP    = 3'd1;
  localparam kind_t K_SET    = 3'd2;
  localparam kind_t K_GET    = 3'd3;
  localparam kind_t K_REMOVE = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic    fin;
    data_t   data;
    status_t status;
    cnt_t    count;
  } res_t;

endpackage

### rtl/core/isstore_ram.sv
`timescale 1ns / 1ps

module isstore_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/isstore_ctrl.sv
`timescale 1ns / 1ps

module isstore_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  isstore_pkg::kind_t    kind,
  input  isstore_pkg::index_t   index,
  input  isstore_pkg::value_t   value,
  input  isstore_pkg::word_t    rdata,
  output isstore_pkg::mem_req_t mreq,
  output isstore_pkg::res_t     res,
  output logic                  busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_RM    = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;

  logic [2:0]          state, state_next;
  isstore_pkg::cnt_t   count, count_next;
  isstore_pkg::kind_t  op_kind, op_kind_next;
  isstore_pkg::index_t op_idx, op_idx_next;
  isstore_pkg::word_t  op_val, op_val_next;
  isstore_pkg::cnt_t   rd_ptr, rd_ptr_next;
  isstore_pkg::word_t  rm_data, rm_data_next;

  isstore_pkg::cmp_t idx_in_c, idx_op_c, cnt_c;
  isstore_pkg::cnt_t cnt_inc, cnt_dec, ptr_inc, ptr_dec, rm_next;

  assign idx_in_c = isstore_pkg::CMP_W'(index);
  assign idx_op_c = isstore_pkg::CMP_W'(op_idx);
  assign cnt_c    = isstore_pkg::CMP_W'(count);
  assign cnt_inc  = count + 1'b1;
  assign cnt_dec  = count - 1'b1;
  assign ptr_inc  = rd_ptr + 1'b1;
  assign ptr_dec  = rd_ptr - 1'b1;
  assign rm_next  = isstore_pkg::CNT_W'(idx_op_c + 1'b1);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    op_kind_next = op_kind;
    op_idx_next  = op_idx;
    op_val_next  = op_val;
    rd_ptr_next  = rd_ptr;
    rm_data_next = rm_data;
    mreq         = '0;
    res          = '0;
    res.status   = isstore_pkg::ST_OK;
    res.count    = count;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_kind_next = kind;
          op_idx_next  = index;
          op_val_next  = isstore_pkg::word_t'(value);
          case (kind)
            isstore_pkg::K_PUSH: begin
              res.fin = 1'b1;
              if (count == isstore_pkg::DEPTH_C) begin
                res.status = isstore_pkg::ST_FULL;
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = count[isstore_pkg::ADDR_W-1:0];
                mreq.wdata = isstore_pkg::word_t'(value);
                count_next = cnt_inc;
                res.count  = cnt_inc;
              end
            end
            isstore_pkg::K_POP: begin
              if (count == '0) begin
                res.fin    = 1'b1;
                res.status = isstore_pkg::ST_EMPTY;
              end else begin
                mreq.raddr = cnt_dec[isstore_pkg::ADDR_W-1:0];
                state_next = S_RD;
              end
            end
            isstore_pkg::K_SET: begin
              if (idx_in_c >= isstore_pkg::DEPTH_X) begin
                res.fin    = 1'b1;
                res.status = isstore_pkg::ST_FULL;
              end else if (idx_in_c < cnt_c) begin
                mreq.we    = 1'b1;
                mreq.waddr = isstore_pkg::ADDR_W'(index);
                mreq.wdata = isstore_pkg::word_t'(value);
                res.fin    = 1'b1;
              end else begin
                state_next = S_FILL;
              end
            end
            isstore_pkg::K_GET, isstore_pkg::K_REMOVE: begin
              if (idx_in_c >= cnt_c) begin
                res.fin    = 1'b1;
                res.status = isstore_pkg::ST_EMPTY;
              end else begin
                mreq.raddr = isstore_pkg::ADDR_W'(index);
                state_next = (kind == isstore_pkg::K_GET) ? S_RD : S_RM;
              end
            end
            default: begin
              res.fin = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        res.fin  = 1'b1;
        res.data = isstore_pkg::data_t'(rdata);
        if (op_kind == isstore_pkg::K_POP) begin
          count_next = cnt_dec;
          res.count  = cnt_dec;
        end
        state_next = S_IDLE;
      end

      S_RM: begin
        rm_data_next = rdata;
        if (rm_next >= count) begin
          count_next = cnt_dec;
          res.fin    = 1'b1;
          res.data   = isstore_pkg::data_t'(rdata);
          res.count  = cnt_dec;
          state_next = S_IDLE;
        end else begin
          mreq.raddr  = rm_next[isstore_pkg::ADDR_W-1:0];
          rd_ptr_next = rm_next;
          state_next  = S_SHIFT;
        end
      end

      // The word read from rd_ptr lands one place lower while the next one is read.
      S_SHIFT: begin
        mreq.we    = 1'b1;
        mreq.waddr = ptr_dec[isstore_pkg::ADDR_W-1:0];
        mreq.wdata = rdata;
        if (ptr_inc < count) begin
          mreq.raddr  = ptr_inc[isstore_pkg::ADDR_W-1:0];
          rd_ptr_next = ptr_inc;
        end else begin
          count_next = cnt_dec;
          res.fin    = 1'b1;
          res.data   = isstore_pkg::data_t'(rm_data);
          res.count  = cnt_dec;
          state_next = S_IDLE;
        end
      end

      // The gap below the target index is zeroed one entry per cycle, then the value lands at the index.
      S_FILL: begin
        mreq.we    = 1'b1;
        mreq.waddr = count[isstore_pkg::ADDR_W-1:0];
        count_next = cnt_inc;
        if (cnt_c == idx_op_c) begin
          mreq.wdata = op_val;
          res.fin    = 1'b1;
          res.count  = cnt_inc;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    op_kind <= op_kind_next;
    op_idx  <= op_idx_next;
    op_val  <= op_val_next;
    rd_ptr  <= rd_ptr_next;
    rm_data <= rm_data_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= isstore_pkg::DEPTH_C)
    else $error("fill count exceeds capacity");

  a_fin_source: assert property (@(posedge clk) disable iff (rst)
    res.fin |-> (state != S_IDLE) || start)
    else $error("result issued without a word in progress");

  a_shift_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (rd_ptr < count) && (isstore_pkg::CMP_W'(rd_ptr) > idx_op_c))
    else $error("shift pointer outside the removed range");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> !mreq.we)
    else $error("write issued during a plain read");

  a_fill_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (cnt_c <= idx_op_c))
    else $error("gap fill ran past the target index");

endmodule

### rtl/core/indexed_stack_store_core.sv
`timescale 1ns / 1ps
// Steps from accept to done: push, in-range set and every failure finish in the
// accepting state; pop and get add one RAM read; remove adds one RAM read plus one
// read/write shift per later entry; a set past the count adds one zero-fill write
// per gap entry. busy covers all of it, so a new word is taken only after the last
// has finished. done pulses for one cycle and cannot be stalled.
// Synchronous reset clears the count; the RAM is not cleared and is read only below it.

module indexed_stack_store_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  isstore_pkg::kind_t         kind,
  input  isstore_pkg::index_t        index,
  input  isstore_pkg::value_t        value,
  output logic                       done,
  output isstore_pkg::data_t         data_out,
  output isstore_pkg::status_t       status,
  output isstore_pkg::fill_t         fill_count
);

  isstore_pkg::mem_req_t mreq;
  isstore_pkg::res_t     res;
  isstore_pkg::word_t    rdata;

  isstore_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .index (index),
    .value (value),
    .rdata (rdata),
    .mreq  (mreq),
    .res   (res),
    .busy  (busy)
  );

  isstore_ram #(
    .WIDTH (isstore_pkg::WORD_BITS),
    .DEPTH (isstore_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  // Result register: one word per finished command, shown for a single cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.fin;
    end
    data_out   <= res.data;
    status     <= res.status;
    fill_count <= isstore_pkg::FILL_W'(res.count);
  end

endmodule
